>>> rtl/core/complex_mix_comb_power_detector_macros.svh
// assertion macros shared by the detector rtl
// no dependencies; included by files that carry concurrent checks
`ifndef COMPLEX_MIX_COMB_POWER_DETECTOR_MACROS_SVH
`define COMPLEX_MIX_COMB_POWER_DETECTOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CMCPD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cmcpd check failed");

// next-cycle implication, disabled while reset is low
`define CMCPD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cmcpd check failed");

`endif

>>> rtl/core/cmcpd_pkg.sv
// shared types, constants and the cosine rom generator function
// no dependencies; imported by every detector module that needs it
package cmcpd_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int COMB_DEPTH_DEF = 64;
    localparam int SAMPLE_W       = 16;
    localparam int POWER_W        = 44;
    localparam int STEP_W         = 8;
    localparam int LEN_W          = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 8;
    localparam int ROM_MAX        = 32767;

    localparam logic [LEN_W-1:0] COMB_LEN_RST = LEN_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP  = 1'b0,
        REG_COMB_LENGTH = 1'b1
    } cfg_reg_t;

    // one comb delay entry: real and imaginary product
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } delay_pair_t;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

    // (2i-1)*(2i) for the taylor terms x^2 .. x^16
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
    };

    // cos of a folded q30 angle in [0, pi/2], scaled to q1.15 and signed
    function automatic logic signed [SAMPLE_W-1:0] cos_q15(input logic [63:0] x,
                                                           input logic neg);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic [63:0]        v;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        s  = signed'(ONE_Q30);
        for (int i = 0; i < 8; i++) begin
            t = ((t * x2) >> 30) / TAYLOR_DIV[i];
            if (i[0] == 1'b0) begin
                s = s - signed'(t);
            end else begin
                s = s + signed'(t);
            end
        end
        if (s < 0) begin
            s = '0;
        end
        if (s > signed'(ONE_Q30)) begin
            s = signed'(ONE_Q30);
        end
        v = ($unsigned(s) * 64'(ROM_MAX) + HALF_Q30) >> 30;
        return neg ? -SAMPLE_W'(v) : SAMPLE_W'(v);
    endfunction

endpackage

>>> rtl/core/complex_mix_comb_power_detector.sv
// quadrature mixer, moving-sum comb pair and power detector, top level
// depends on cmcpd_pkg, cmcpd_cos_rom, cmcpd_ram, cmcpd_mult and the macros header
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------
//  s_       | in  | s_valid / s_ready  | s_sample   (16 bit signed)
//  m_       | out | m_valid / m_ready  | m_power    (44 bit unsigned)
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// words are taken back to back, a new one only as the last leaves the final step,
// set by the single shared multiplier doing cos product, sin product, real square
// and imag square in turn; the result is registered onto m_valid from that step.
// after reset a clearing pass writes zero to every entry of the comb ram; no
// sample is taken meanwhile, config writes are.
// a stalled m_ready holds one result in the output register; the next word is
// still taken, and its result waits in the final step until the register frees.
`include "complex_mix_comb_power_detector_macros.svh"

module complex_mix_comb_power_detector import cmcpd_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int COMB_DEPTH = COMB_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [POWER_W-1:0]         m_power,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int PH_W   = $clog2(TABLE_SIZE);
    localparam int POS_W  = $clog2(COMB_DEPTH);
    localparam int SUM_W  = 17 + $clog2(COMB_DEPTH);
    localparam int PROD_W = 2 * SUM_W;
    localparam int CNT_W  = $clog2(COMB_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int DLY_W  = $bits(delay_pair_t);

    localparam logic [PH_W:0]    TBL_N     = (PH_W + 1)'(TABLE_SIZE);
    localparam logic [PH_W:0]    QUARTER   = (PH_W + 1)'(TABLE_SIZE / 4);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(COMB_DEPTH);
    localparam logic [POS_W-1:0] LAST_ADDR = POS_W'(COMB_DEPTH - 1);
    localparam logic signed [SUM_W-1:0] SUM_LIM = SUM_W'(COMB_DEPTH * ROM_MAX);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_IM,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [PH_W-1:0]            phase_reg, phase_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [POS_W-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [STEP_W-1:0]          phase_step_reg, phase_step_next;
    logic [LEN_W-1:0]           comb_length_reg, comb_length_next;
    logic signed [SUM_W-1:0]    real_sum_reg, real_sum_next;
    logic signed [SUM_W-1:0]    imag_sum_reg, imag_sum_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [SAMPLE_W-1:0] re_hold_reg, re_hold_next;
    logic [PROD_W-1:0]          acc_reg, acc_next;
    logic                       m_valid_reg, m_valid_next;
    logic [POWER_W-1:0]         m_power_reg, m_power_next;

    logic [PH_W-1:0]            step_mod_tab [2**STEP_W];
    logic [PH_W-1:0]            step_mod;
    logic [PH_W:0]              phase_sum, cos_sum;
    logic [PH_W-1:0]            phase_adv, cos_ph;
    logic [CMP_W-1:0]           len_eff, pos_inc;

    logic [PH_W-1:0]            rom_addr;
    logic signed [SAMPLE_W-1:0] rom_q;
    logic                       ram_we;
    logic [POS_W-1:0]           ram_wa;
    delay_pair_t                ram_wd;
    logic [DLY_W-1:0]           ram_rd_data;
    delay_pair_t                ram_rd;

    logic                       mul_en;
    logic signed [SUM_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   mult_q;
    logic signed [SAMPLE_W-1:0] prod_trunc;
    logic [PROD_W-1:0]          sq_sum;
    logic                       out_free;
    logic                       start;
    logic                       sums_in_range;

    // phase_step reduced modulo the table size
    for (genvar i = 0; i < 2**STEP_W; i++) begin : g_step_mod
        assign step_mod_tab[i] = PH_W'(i % TABLE_SIZE);
    end

    assign step_mod  = step_mod_tab[phase_step_reg];
    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_mod};
    assign phase_adv = (phase_sum >= TBL_N) ? PH_W'(phase_sum - TBL_N) : PH_W'(phase_sum);
    assign cos_sum   = {1'b0, phase_reg} + QUARTER;
    assign cos_ph    = (cos_sum >= TBL_N) ? PH_W'(cos_sum - TBL_N) : PH_W'(cos_sum);

    always_comb begin
        if (comb_length_reg == '0) begin
            len_eff = CMP_W'(1);
        end else if (CMP_W'(comb_length_reg) > DEPTH_CMP) begin
            len_eff = DEPTH_CMP;
        end else begin
            len_eff = CMP_W'(comb_length_reg);
        end
    end

    assign pos_inc = CMP_W'(pos_reg) + CMP_W'(1);

    // floor of the q2.30 product down to q1.15
    assign prod_trunc = mult_q[30:15];
    assign sq_sum     = acc_reg + $unsigned(mult_q);
    assign ram_rd     = ram_rd_data;
    assign out_free   = !m_valid_reg || m_ready;

    assign sums_in_range = (real_sum_reg <= SUM_LIM) && (real_sum_reg >= -SUM_LIM) &&
                           (imag_sum_reg <= SUM_LIM) && (imag_sum_reg >= -SUM_LIM);

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_power   = m_power_reg;

    cmcpd_cos_rom #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (rom_q)
    );

    cmcpd_ram #(
        .WIDTH (DLY_W),
        .DEPTH (COMB_DEPTH)
    ) u_comb_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (pos_reg),
        .rd_data (ram_rd_data)
    );

    cmcpd_mult #(
        .OP_W (SUM_W)
    ) u_mult (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mult_q)
    );

    always_comb begin
        phase_step_next  = phase_step_reg;
        comb_length_next = comb_length_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PHASE_STEP: begin
                    phase_step_next = cfg_data[STEP_W-1:0];
                end
                REG_COMB_LENGTH: begin
                    comb_length_next = cfg_data[LEN_W-1:0];
                end
                default: begin
                    phase_step_next = phase_step_reg;
                end
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        clr_cnt_next  = clr_cnt_reg;
        real_sum_next = real_sum_reg;
        imag_sum_next = imag_sum_reg;
        sample_next   = sample_reg;
        re_hold_next  = re_hold_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_power_next  = m_power_reg;
        s_ready       = 1'b0;
        start         = 1'b0;
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        ram_we        = 1'b0;
        ram_wa        = pos_reg;
        ram_wd        = '0;
        // rom sits on the cos entry so a new word can start at once
        rom_addr      = cos_ph;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_wa       = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + POS_W'(1);
                if (clr_cnt_reg == LAST_ADDR) begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                start   = s_valid;
            end
            ST_MUL_IM: begin
                mul_en        = 1'b1;
                mul_a         = SUM_W'(sample_reg);
                mul_b         = SUM_W'(rom_q);
                real_sum_next = real_sum_reg - SUM_W'(ram_rd.re) + SUM_W'(prod_trunc);
                re_hold_next  = prod_trunc;
                state_next    = ST_SQ_RE;
            end
            ST_SQ_RE: begin
                mul_en        = 1'b1;
                mul_a         = real_sum_reg;
                mul_b         = real_sum_reg;
                imag_sum_next = imag_sum_reg - SUM_W'(ram_rd.im) + SUM_W'(prod_trunc);
                ram_we        = 1'b1;
                ram_wd.re     = re_hold_reg;
                ram_wd.im     = prod_trunc;
                pos_next      = (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];
                phase_next    = phase_adv;
                state_next    = ST_SQ_IM;
            end
            ST_SQ_IM: begin
                mul_en     = 1'b1;
                mul_a      = imag_sum_reg;
                mul_b      = imag_sum_reg;
                acc_next   = $unsigned(mult_q);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // product register holds the imag square until the result leaves
                if (out_free) begin
                    s_ready      = 1'b1;
                    m_valid_next = 1'b1;
                    m_power_next = POWER_W'(sq_sum);
                    state_next   = ST_IDLE;
                    start        = s_valid;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (start) begin
            sample_next = s_sample;
            mul_en      = 1'b1;
            mul_a       = SUM_W'(s_sample);
            mul_b       = SUM_W'(rom_q);
            rom_addr    = phase_reg;
            state_next  = ST_MUL_IM;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            phase_reg       <= '0;
            pos_reg         <= '0;
            clr_cnt_reg     <= '0;
            phase_step_reg  <= '0;
            comb_length_reg <= COMB_LEN_RST;
            real_sum_reg    <= '0;
            imag_sum_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            clr_cnt_reg     <= clr_cnt_next;
            phase_step_reg  <= phase_step_next;
            comb_length_reg <= comb_length_next;
            real_sum_reg    <= real_sum_next;
            imag_sum_reg    <= imag_sum_next;
            m_valid_reg     <= m_valid_next;
        end
        sample_reg  <= sample_next;
        re_hold_reg <= re_hold_next;
        acc_reg     <= acc_next;
        m_power_reg <= m_power_next;
    end

    `CMCPD_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `CMCPD_ASSERT_IMP(a_result_from_done, aclk, aresetn, $rose(m_valid), $past(state_reg) == ST_DONE)
    `CMCPD_ASSERT_IMP(a_sums_bounded, aclk, aresetn, 1'b1, sums_in_range)
    `CMCPD_ASSERT_IMP(a_pos_in_depth, aclk, aresetn, 1'b1, (pos_reg <= LAST_ADDR) && (clr_cnt_reg <= LAST_ADDR))

endmodule

>>> rtl/core/cmcpd_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module cmcpd_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/cmcpd_cos_rom.sv
// one-period cosine rom in q1.15, built at elaboration, registered read
// depends on cmcpd_pkg (cos_q15, PI_Q30)
module cmcpd_cos_rom import cmcpd_pkg::*; #(
    parameter  int TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int ADDR_W     = $clog2(TABLE_SIZE)
) (
    input  logic                       aclk,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] cos_rom [TABLE_SIZE];

    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_entry
        // fold the angle into the first quadrant, remember the sign
        localparam int unsigned FOLD  = (2 * k > TABLE_SIZE) ? TABLE_SIZE - k : k;
        localparam int unsigned ANG   = 2 * FOLD;
        localparam bit          NEG   = (2 * ANG > TABLE_SIZE);
        localparam int unsigned ANG_Q = NEG ? TABLE_SIZE - ANG : ANG;
        localparam logic [63:0] X     = (PI_Q30 * 64'(ANG_Q)) / 64'(TABLE_SIZE);
        localparam logic signed [SAMPLE_W-1:0] VAL = cos_q15(X, NEG);
        assign cos_rom[k] = VAL;
    end

    always_ff @(posedge aclk) begin
        rd_data <= cos_rom[rd_addr];
    end

endmodule

>>> rtl/core/cmcpd_mult.sv
// shared signed multiplier with registered product and load enable
// no dependencies
module cmcpd_mult #(
    parameter  int OP_W   = 23,
    localparam int PROD_W = 2 * OP_W
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [OP_W-1:0]   a,
    input  logic signed [OP_W-1:0]   b,
    output logic signed [PROD_W-1:0] p
);

    always_ff @(posedge aclk) begin
        if (en) begin
            p <= a * b;
        end
    end

endmodule

>>> sim/complex_mix_comb_power_detector_tb.sv
// self-checking testbench for the quadrature mixer / comb / power detector
// depends on cmcpd_pkg and the complex_mix_comb_power_detector rtl
`timescale 1ns / 1ps

module complex_mix_comb_power_detector_tb import cmcpd_pkg::*;;

    localparam int          ROM_SIZE   = 256;
    localparam int          LINE_DEPTH = 64;
    localparam logic [63:0] PI_FIX     = 64'd3373259426;
    localparam int          PHASE_ITEMS = 190;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample  = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic [POWER_W-1:0]         m_power;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = REG_PHASE_STEP;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;

    // predictor state
    logic signed [SAMPLE_W-1:0] cos_rom [ROM_SIZE];
    logic [STEP_W-1:0]          step_reg     = '0;
    logic [LEN_W-1:0]           comb_len_reg = COMB_LEN_RST;
    logic [7:0]                 carrier_phase = '0;
    int unsigned                comb_pos = 0;
    longint                     real_line [LINE_DEPTH];
    longint                     imag_line [LINE_DEPTH];
    longint                     real_acc = 0;
    longint                     imag_acc = 0;

    logic signed [SAMPLE_W-1:0] pending_samples [$];
    logic [POWER_W-1:0]         expected_power [$];
    int                         send_idle_pct  = 0;
    int                         recv_stall_pct = 0;
    int                         errors = 0;

    complex_mix_comb_power_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_power   (m_power),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // taylor series cosine worked in q30 and scaled to q1.15, folded to the first quadrant
    function automatic logic signed [SAMPLE_W-1:0] cosine_entry(input int unsigned k);
        int unsigned     j;
        int unsigned     a;
        logic            flip;
        logic [63:0]     x;
        logic [63:0]     x2;
        logic [63:0]     t;
        longint          s;
        longint unsigned v;
        j    = (2 * k > ROM_SIZE) ? ROM_SIZE - k : k;
        a    = 2 * j;
        flip = 1'b0;
        if (2 * a > ROM_SIZE) begin
            flip = 1'b1;
            a    = ROM_SIZE - a;
        end
        x  = (PI_FIX * 64'(a)) / 64'(ROM_SIZE);
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        s  = longint'(t);
        for (int i = 1; i <= 8; i++) begin
            t = ((t * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
            if (i % 2 == 1) begin
                s = s - longint'(t);
            end else begin
                s = s + longint'(t);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        if (s > (longint'(1) << 30)) begin
            s = longint'(1) << 30;
        end
        v = (longint'(s) * 32767 + (longint'(1) << 29)) >> 30;
        return flip ? -SAMPLE_W'(v) : SAMPLE_W'(v);
    endfunction

    // mix one sample, update both combs, return the detected power
    function automatic logic [POWER_W-1:0] mix_and_detect(input logic signed [SAMPLE_W-1:0] smp);
        int unsigned imag_idx;
        int unsigned real_idx;
        int unsigned span;
        int unsigned slot;
        longint      re_prod;
        longint      im_prod;
        longint      re_mag;
        longint      im_mag;
        imag_idx = carrier_phase;
        real_idx = (imag_idx + ROM_SIZE / 4) % ROM_SIZE;
        span     = comb_len_reg;
        if (span == 0) begin
            span = 1;
        end
        if (span > LINE_DEPTH) begin
            span = LINE_DEPTH;
        end
        slot = comb_pos % LINE_DEPTH;
        // arithmetic shift gives the floor of the q2.30 product
        re_prod = (longint'(smp) * longint'(cos_rom[real_idx])) >>> 15;
        im_prod = (longint'(smp) * longint'(cos_rom[imag_idx])) >>> 15;
        real_acc = real_acc - real_line[slot] + re_prod;
        imag_acc = imag_acc - imag_line[slot] + im_prod;
        real_line[slot] = re_prod;
        imag_line[slot] = im_prod;
        // a position left beyond a shortened comb is used once, then wraps
        slot++;
        if (slot >= span) begin
            slot = 0;
        end
        comb_pos      = slot;
        carrier_phase = 8'(imag_idx + step_reg);
        re_mag = (real_acc < 0) ? -real_acc : real_acc;
        im_mag = (imag_acc < 0) ? -imag_acc : imag_acc;
        return POWER_W'(re_mag * re_mag + im_mag * im_mag);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] val;
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: val = 16'sh8000;
                1: val = 16'sh7fff;
                2: val = 16'sh0000;
                default: val = 16'shffff;
            endcase
        end else begin
            val = SAMPLE_W'($urandom_range(0, 65535));
        end
        return val;
    endfunction

    // sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_power.push_back(mix_and_detect(s_sample));
            end
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid  <= 1'b1;
                s_sample <= pending_samples.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        logic [POWER_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_power.size() == 0) begin
                    $display("%0t: unexpected power word, actual %0d", $time, m_power);
                    errors++;
                end else begin
                    want = expected_power.pop_front();
                    if (m_power !== want) begin
                        $display("%0t: power mismatch, expected %0d actual %0d",
                                 $time, want, m_power);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_PHASE_STEP) begin
            step_reg = val;
        end else begin
            comb_len_reg = val[LEN_W-1:0];
        end
    endtask

    // wait until every sample is taken and every result has come back
    task automatic drain();
        while (pending_samples.size() != 0 || s_valid || expected_power.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] step_val;
        logic [CFG_DATA_W-1:0] len_val;
        for (int k = 0; k < ROM_SIZE; k++) begin
            cos_rom[k] = cosine_entry(k);
        end
        for (int k = 0; k < LINE_DEPTH; k++) begin
            real_line[k] = 0;
            imag_line[k] = 0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: full-scale extremes and bit patterns
        @(negedge aclk);
        pending_samples = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                            16'sh5555, 16'shaaaa, 16'sh8000};
        drain();

        // largest step wraps the phase, oversized length clamps to full depth
        write_reg(REG_PHASE_STEP, 8'hff);
        write_reg(REG_COMB_LENGTH, 8'hff);
        @(negedge aclk);
        pending_samples = '{16'sh8000, 16'sh8000, 16'sh8000,
                            16'sh7fff, 16'sh7fff, 16'sh7fff};
        drain();

        // zero length acts as one, while the position sits past the new length
        write_reg(REG_COMB_LENGTH, 8'h00);
        write_reg(REG_PHASE_STEP, 8'h40);
        @(negedge aclk);
        pending_samples = '{16'sh7fff, 16'sh8000, 16'sh1234, 16'shedcb};
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: step_val = 8'd255;
                1: step_val = 8'd0;
                2: step_val = 8'd1;
                3: step_val = 8'd64;
                default: step_val = CFG_DATA_W'($urandom_range(0, 255));
            endcase
            case (p)
                0: len_val = 8'd1;
                1: len_val = 8'hc0;
                2: len_val = 8'd64;
                3: len_val = 8'd0;
                4: len_val = 8'd2;
                default: len_val = CFG_DATA_W'($urandom_range(0, 255));
            endcase
            write_reg(REG_COMB_LENGTH, len_val);
            write_reg(REG_PHASE_STEP, step_val);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            @(negedge aclk);
            for (int n = 0; n < PHASE_ITEMS / 2; n++) begin
                pending_samples.push_back(pick_sample());
            end
            // odd phases hold the sender off until the pipe is empty
            if (p % 2 == 1) begin
                drain();
            end
            for (int n = PHASE_ITEMS / 2; n < PHASE_ITEMS; n++) begin
                pending_samples.push_back(pick_sample());
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/cmcpd_pkg.sv
rtl/core/cmcpd_ram.sv
rtl/core/cmcpd_cos_rom.sv
rtl/core/cmcpd_mult.sv
rtl/core/complex_mix_comb_power_detector.sv
sim/complex_mix_comb_power_detector_tb.sv
